[rtl/core/marker_nearest_match_tracker_assert.svh]
// assertion macros for the marker tracker checks
`ifndef MARKER_NEAREST_MATCH_TRACKER_ASSERT_SVH
`define MARKER_NEAREST_MATCH_TRACKER_ASSERT_SVH

// consequent in the cycle after the antecedent, ignored while in reset
`define MNMT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker check failed in %m");

// consequent in the cycle after the antecedent, reset included
`define MNMT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tracker check failed in %m");

`endif

[rtl/core/mnmt_pkg.sv]
`default_nettype none
package mnmt_pkg;

   localparam int MARKERS_DEFAULT = 16;
   localparam int COORD_W = 24;
   localparam int VEL_W   = 25;
   localparam int FRAME_W = 32;
   localparam int TOL_W   = 48;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 48;
   localparam int INDEX_OUT_W = 6;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MATCH_TOL  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRED_LIMIT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEFAULT_X  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEFAULT_Y  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEFAULT_Z  = 3'd5;

   localparam logic [TOL_W-1:0] TOL_RESET   = 48'd1024;
   localparam logic [7:0]       PRED_RESET  = 8'd1;
   localparam logic [7:0]       TIMEOUT_RESET = 8'd6;
   // seen stamp after reset: all ones minus the reset timeout
   localparam logic [FRAME_W-1:0] SEEN_RESET = '1 - FRAME_W'(TIMEOUT_RESET);

   localparam logic FUNC_POINT = 1'b0;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [VEL_W-1:0]   vel_x;
      logic signed [VEL_W-1:0]   vel_y;
      logic signed [VEL_W-1:0]   vel_z;
      logic [FRAME_W-1:0]        seen;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{pos_x: '0, pos_y: '0, pos_z: '0,
                                         vel_x: '0, vel_y: '0, vel_z: '0,
                                         seen: SEEN_RESET};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PT_WR,
      ST_EOF_RD,
      ST_EOF_UPD
   } state_type;

endpackage
`default_nettype wire

[rtl/core/marker_nearest_match_tracker.sv]
`default_nettype none
// channel  | dir | handshake              | payload
// req      | in  | req_tvalid/req_tready  | tdata pos_x,pos_y,pos_z; tuser func
// rsp      | out | rsp_tvalid/rsp_tready  | tdata marker_index,out_x,out_y,out_z;
//          |     |                        | tuser visible; tlast last_report
// csr      | in  | csr_we                 | csr_addr register index, csr_wdata value
//
// a point takes one read per marker, a square and a compare stage and a write-back
// at an end of frame each marker is a read then a write on the single memory port,
// and its report is loaded with the write
// reset clears control and entry valid bits and loads config reset values; unwritten entries read as reset
// a stalled rsp holds the frame walk; req is taken only when the block is idle
module marker_nearest_match_tracker #(
   parameter int MARKERS = mnmt_pkg::MARKERS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // pos_x, pos_y, pos_z
   input  wire logic        req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // marker_index, out_x, out_y, out_z, 2 pad
   output logic             rsp_tuser,   // visible
   output logic             rsp_tlast,   // last_report
   input  wire logic        csr_we,
   input  wire logic [mnmt_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [mnmt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IdxW = (MARKERS > 1) ? $clog2(MARKERS) : 1;
   localparam int CntW = $clog2(MARKERS + 1);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(MARKERS - 1);
   localparam int SqW  = 54;
   localparam int SumW = 56;

   // configuration
   logic [mnmt_pkg::TOL_W-1:0]   tol_ff;
   logic [7:0]                   plimit_ff;
   logic [7:0]                   timeout_ff;
   logic signed [23:0]           def_x_ff, def_y_ff, def_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff     <= mnmt_pkg::TOL_RESET;
         plimit_ff  <= mnmt_pkg::PRED_RESET;
         timeout_ff <= mnmt_pkg::TIMEOUT_RESET;
         def_x_ff   <= '0;
         def_y_ff   <= '0;
         def_z_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            mnmt_pkg::CSR_MATCH_TOL:  tol_ff     <= csr_wdata;
            mnmt_pkg::CSR_PRED_LIMIT: plimit_ff  <= csr_wdata[7:0];
            mnmt_pkg::CSR_TIMEOUT:    timeout_ff <= csr_wdata[7:0];
            mnmt_pkg::CSR_DEFAULT_X:  def_x_ff   <= csr_wdata[23:0];
            mnmt_pkg::CSR_DEFAULT_Y:  def_y_ff   <= csr_wdata[23:0];
            mnmt_pkg::CSR_DEFAULT_Z:  def_z_ff   <= csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // marker memory, one port, registered read
   mnmt_pkg::entry_type mem [MARKERS];
   logic [MARKERS-1:0]  valid_ff;
   mnmt_pkg::entry_type rd_ff;
   logic                rd_vld_ff;

   logic                mem_re;
   logic                mem_we;
   logic [IdxW-1:0]     mem_raddr;
   logic [IdxW-1:0]     mem_waddr;
   mnmt_pkg::entry_type mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff     <= mem[mem_raddr];
         rd_vld_ff <= valid_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[mem_waddr] <= 1'b1;
      end
   end

   // never-written entries read as the reset entry
   mnmt_pkg::entry_type ent;
   assign ent = rd_vld_ff ? rd_ff : mnmt_pkg::ENTRY_RESET;

   // control
   mnmt_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]  cnt_ff;
   logic [31:0]      frame_ff;
   logic signed [23:0] pt_x_ff, pt_y_ff, pt_z_ff;

   // scan pipeline
   logic             v1_ff;
   logic [IdxW-1:0]  i1_ff;
   logic             v2_ff;
   logic [IdxW-1:0]  i2_ff;
   logic             live2_ff, fresh2_ff;
   logic signed [23:0] p2x_ff, p2y_ff, p2z_ff;
   logic [SqW-1:0]   sqx_ff, sqy_ff, sqz_ff;

   logic [SumW-1:0]  best_ff;
   logic             found_ff, bfresh_ff;
   logic [IdxW-1:0]  bidx_ff;
   logic signed [23:0] bx_ff, by_ff, bz_ff;
   logic             rec_ff;
   logic [IdxW-1:0]  ridx_ff;

   // result register
   logic             rsp_valid_ff;
   logic [IdxW-1:0]  rsp_idx_ff;
   logic signed [23:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic             rsp_vis_ff, rsp_last_ff;

   logic accept;
   logic rsp_free;
   logic rsp_load;
   logic scan_done;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign scan_done = v2_ff && (i2_ff == LastIdx);

   // age and distance terms of the entry just read
   logic [31:0] age;
   logic        live;
   logic signed [25:0] pred_x, pred_y, pred_z;
   logic signed [26:0] d_x, d_y, d_z;
   logic signed [SqW-1:0] m_x, m_y, m_z;

   always_comb begin
      age    = frame_ff - ent.seen;
      live   = age <= {24'd0, timeout_ff};
      pred_x = 26'(ent.pos_x) + 26'(ent.vel_x);
      pred_y = 26'(ent.pos_y) + 26'(ent.vel_y);
      pred_z = 26'(ent.pos_z) + 26'(ent.vel_z);
      d_x    = 27'(pt_x_ff) - 27'(pred_x);
      d_y    = 27'(pt_y_ff) - 27'(pred_y);
      d_z    = 27'(pt_z_ff) - 27'(pred_z);
      m_x    = d_x * d_x;
      m_y    = d_y * d_y;
      m_z    = d_z * d_z;
   end

   logic [SumW-1:0] sum2;
   assign sum2 = SumW'(sqx_ff) + SumW'(sqy_ff) + SumW'(sqz_ff);

   // frame update of the entry just read
   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      logic signed [23:0] r;
      if (v > 26'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -26'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   logic vis;
   logic signed [23:0] nx, ny, nz;
   always_comb begin
      vis = age <= {24'd0, plimit_ff};
      priority if (!live) begin
         nx = def_x_ff;
         ny = def_y_ff;
         nz = def_z_ff;
      end else if ((age != '0) && vis) begin
         nx = sat24(pred_x);
         ny = sat24(pred_y);
         nz = sat24(pred_z);
      end else begin
         nx = ent.pos_x;
         ny = ent.pos_y;
         nz = ent.pos_z;
      end
   end

   // next state and memory control
   always_comb begin
      state_in  = state_ff;
      req_tready = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_raddr = cnt_ff[IdxW-1:0];
      mem_waddr = cnt_ff[IdxW-1:0];
      mem_wdata = ent;
      rsp_load  = 1'b0;
      unique case (state_ff)
         mnmt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = (req_tuser == mnmt_pkg::FUNC_POINT) ?
                          mnmt_pkg::ST_SCAN : mnmt_pkg::ST_EOF_RD;
            end
         end
         mnmt_pkg::ST_SCAN: begin
            mem_re = cnt_ff < CntW'(MARKERS);
            if (scan_done) begin
               state_in = mnmt_pkg::ST_PT_WR;
            end
         end
         mnmt_pkg::ST_PT_WR: begin
            state_in = mnmt_pkg::ST_IDLE;
            mem_wdata.pos_x = pt_x_ff;
            mem_wdata.pos_y = pt_y_ff;
            mem_wdata.pos_z = pt_z_ff;
            mem_wdata.seen  = frame_ff;
            if (found_ff) begin
               mem_we    = !bfresh_ff;
               mem_waddr = bidx_ff;
               mem_wdata.vel_x = 25'(pt_x_ff) - 25'(bx_ff);
               mem_wdata.vel_y = 25'(pt_y_ff) - 25'(by_ff);
               mem_wdata.vel_z = 25'(pt_z_ff) - 25'(bz_ff);
            end else begin
               mem_we    = rec_ff;
               mem_waddr = ridx_ff;
               mem_wdata.vel_x = '0;
               mem_wdata.vel_y = '0;
               mem_wdata.vel_z = '0;
            end
         end
         mnmt_pkg::ST_EOF_RD: begin
            mem_re   = 1'b1;
            state_in = mnmt_pkg::ST_EOF_UPD;
         end
         mnmt_pkg::ST_EOF_UPD: begin
            mem_wdata.pos_x = nx;
            mem_wdata.pos_y = ny;
            mem_wdata.pos_z = nz;
            if (rsp_free) begin
               mem_we   = 1'b1;
               rsp_load = 1'b1;
               state_in = (cnt_ff[IdxW-1:0] == LastIdx) ?
                          mnmt_pkg::ST_IDLE : mnmt_pkg::ST_EOF_RD;
            end
         end
         default: state_in = mnmt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mnmt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // counters, frame count, scan pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         frame_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         v1_ff <= (state_ff == mnmt_pkg::ST_SCAN) && mem_re;
         v2_ff <= v1_ff;
         if (accept) begin
            cnt_ff <= '0;
         end else if (((state_ff == mnmt_pkg::ST_SCAN) && mem_re) || rsp_load) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (rsp_load && (cnt_ff[IdxW-1:0] == LastIdx)) begin
            frame_ff <= frame_ff + 1'b1;
         end
      end
   end

   // point capture, squares and best-match search
   always_ff @(posedge clock) begin
      if (accept) begin
         pt_x_ff <= req_tdata[23:0];
         pt_y_ff <= req_tdata[47:24];
         pt_z_ff <= req_tdata[71:48];
      end
      i1_ff     <= mem_raddr;
      i2_ff     <= i1_ff;
      live2_ff  <= live;
      fresh2_ff <= age == '0;
      p2x_ff    <= ent.pos_x;
      p2y_ff    <= ent.pos_y;
      p2z_ff    <= ent.pos_z;
      sqx_ff    <= m_x;
      sqy_ff    <= m_y;
      sqz_ff    <= m_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         rec_ff   <= 1'b0;
      end else if (accept) begin
         found_ff <= 1'b0;
         rec_ff   <= 1'b0;
         best_ff  <= SumW'(tol_ff);
      end else if (v2_ff) begin
         priority if (live2_ff && (sum2 < best_ff)) begin
            best_ff   <= sum2;
            found_ff  <= 1'b1;
            bidx_ff   <= i2_ff;
            bfresh_ff <= fresh2_ff;
            bx_ff     <= p2x_ff;
            by_ff     <= p2y_ff;
            bz_ff     <= p2z_ff;
         end else if (!live2_ff && !rec_ff) begin
            // first timed-out slot is the reclaim candidate
            rec_ff  <= 1'b1;
            ridx_ff <= i2_ff;
         end else begin
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_idx_ff  <= cnt_ff[IdxW-1:0];
         rsp_x_ff    <= nx;
         rsp_y_ff    <= ny;
         rsp_z_ff    <= nz;
         rsp_vis_ff  <= vis;
         rsp_last_ff <= cnt_ff[IdxW-1:0] == LastIdx;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_z_ff, rsp_y_ff, rsp_x_ff,
                        mnmt_pkg::INDEX_OUT_W'(rsp_idx_ff)};
   assign rsp_tuser  = rsp_vis_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

[rtl/core/mnmt_chk.sv]
`default_nettype none
`include "marker_nearest_match_tracker_assert.svh"
module mnmt_chk (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic rsp_tlast
);

   // a stalled result beat stays offered
   `MNMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // nothing is offered straight out of reset
   `MNMT_ASSERT_NEXT_ALWAYS(a_rsp_reset, clock, reset, !rsp_tvalid)
   // an accepted item leaves the block busy in the next cycle
   `MNMT_ASSERT_NEXT(a_req_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   // a stalled result beat keeps its last flag
   `MNMT_ASSERT_NEXT(a_last_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     $stable(rsp_tlast))

endmodule

bind marker_nearest_match_tracker mnmt_chk u_mnmt_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

[test/mnmt_tracker_check.sv]
`default_nettype none
module mnmt_tracker_check
   import mnmt_pkg::*;
#(
   parameter int MARKERS = MARKERS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [71:0]           req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [79:0]           rsp_tdata,
   input  wire logic                  rsp_tuser,
   input  wire logic                  rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         errors,
   output int                         reports_seen,
   output int                         reports_pending
);

   typedef struct {
      logic [5:0]         idx;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic               vis;
      logic               last;
   } report_t;

   report_t expected_reports[$];

   logic [TOL_W-1:0]          tol_sq;
   logic [7:0]                pred_lim;
   logic [7:0]                timeout;
   logic signed [COORD_W-1:0] dflt_x, dflt_y, dflt_z;
   logic [FRAME_W-1:0]        frame_no;
   logic signed [COORD_W-1:0] px[MARKERS], py[MARKERS], pz[MARKERS];
   logic signed [VEL_W-1:0]   vx[MARKERS], vy[MARKERS], vz[MARKERS];
   logic [FRAME_W-1:0]        seen[MARKERS];

   task automatic report(input string what, input int idx, input longint got,
                         input longint want);
      $display("mismatch: %s marker %0d got %0h want %0h", what, idx, got, want);
      errors++;
   endtask

   function automatic logic signed [23:0] sat_add(logic signed [23:0] p,
                                                  logic signed [24:0] v);
      longint s;
      s = longint'(p) + longint'(v);
      if (s > 64'sd8388607) return 24'sh7FFFFF;
      if (s < -64'sd8388608) return 24'sh800000;
      return s[23:0];
   endfunction

   // nearest live marker by predicted position, else reclaim first timed-out one
   task automatic track_point(input logic signed [23:0] qx, qy, qz);
      longint unsigned best, d2;
      longint dx, dy, dz;
      int closest, reclaim;
      logic [31:0] age;
      best = tol_sq;
      closest = -1;
      reclaim = -1;
      for (int j = 0; j < MARKERS; j++) begin
         age = frame_no - seen[j];
         if (age <= {24'd0, timeout}) begin
            dx = longint'(qx) - (longint'(px[j]) + longint'(vx[j]));
            dy = longint'(qy) - (longint'(py[j]) + longint'(vy[j]));
            dz = longint'(qz) - (longint'(pz[j]) + longint'(vz[j]));
            d2 = dx * dx + dy * dy + dz * dz;
            if (d2 < best) begin
               best = d2;
               closest = j;
            end
         end else if (reclaim < 0) begin
            reclaim = j;
         end
      end
      if (closest >= 0) begin
         // already updated this frame: point is dropped
         if (seen[closest] != frame_no) begin
            vx[closest] = qx - px[closest];
            vy[closest] = qy - py[closest];
            vz[closest] = qz - pz[closest];
            px[closest] = qx;
            py[closest] = qy;
            pz[closest] = qz;
            seen[closest] = frame_no;
         end
      end else if (reclaim >= 0) begin
         vx[reclaim] = '0;
         vy[reclaim] = '0;
         vz[reclaim] = '0;
         px[reclaim] = qx;
         py[reclaim] = qy;
         pz[reclaim] = qz;
         seen[reclaim] = frame_no;
      end
   endtask

   // age every marker and queue its report
   task automatic close_frame();
      logic [31:0] age;
      report_t r;
      for (int j = 0; j < MARKERS; j++) begin
         age = frame_no - seen[j];
         r.vis = age <= {24'd0, pred_lim};
         if (age > {24'd0, timeout}) begin
            px[j] = dflt_x;
            py[j] = dflt_y;
            pz[j] = dflt_z;
         end else if (age != 0 && r.vis) begin
            px[j] = sat_add(px[j], vx[j]);
            py[j] = sat_add(py[j], vy[j]);
            pz[j] = sat_add(pz[j], vz[j]);
         end
         r.idx = 6'(j);
         r.x = px[j];
         r.y = py[j];
         r.z = pz[j];
         r.last = (j == MARKERS - 1);
         expected_reports.push_back(r);
      end
      frame_no = frame_no + 1;
   endtask

   initial begin
      errors = 0;
      reports_seen = 0;
      reports_pending = 0;
   end

   always @(posedge clock) begin
      report_t w;
      if (reset) begin
         tol_sq = TOL_RESET;
         pred_lim = PRED_RESET;
         timeout = TIMEOUT_RESET;
         dflt_x = '0;
         dflt_y = '0;
         dflt_z = '0;
         frame_no = '0;
         for (int j = 0; j < MARKERS; j++) begin
            px[j] = '0; py[j] = '0; pz[j] = '0;
            vx[j] = '0; vy[j] = '0; vz[j] = '0;
            seen[j] = SEEN_RESET;
         end
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MATCH_TOL:  tol_sq = csr_wdata;
               CSR_PRED_LIMIT: pred_lim = csr_wdata[7:0];
               CSR_TIMEOUT:    timeout = csr_wdata[7:0];
               CSR_DEFAULT_X:  dflt_x = csr_wdata[23:0];
               CSR_DEFAULT_Y:  dflt_y = csr_wdata[23:0];
               CSR_DEFAULT_Z:  dflt_z = csr_wdata[23:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
               report("unexpected beat", int'(rsp_tdata[5:0]), 0, 0);
            end else begin
               w = expected_reports.pop_front();
               if (rsp_tdata[5:0] != w.idx) report("index", w.idx, rsp_tdata[5:0], w.idx);
               if (rsp_tdata[29:6] != w.x) report("x", w.idx, rsp_tdata[29:6], w.x[23:0]);
               if (rsp_tdata[53:30] != w.y) report("y", w.idx, rsp_tdata[53:30], w.y[23:0]);
               if (rsp_tdata[77:54] != w.z) report("z", w.idx, rsp_tdata[77:54], w.z[23:0]);
               if (rsp_tuser != w.vis) report("visible", w.idx, rsp_tuser, w.vis);
               if (rsp_tlast != w.last) report("last", w.idx, rsp_tlast, w.last);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == FUNC_POINT)
               track_point(req_tdata[23:0], req_tdata[47:24], req_tdata[71:48]);
            else
               close_frame();
         end
      end
      reports_pending <= expected_reports.size();
   end

endmodule
`default_nettype wire

[test/tb.sv]
`default_nettype none
module tb;
   import mnmt_pkg::*;

   localparam int NOBJ = 10;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [71:0]           req_tdata;   // pos_x, pos_y, pos_z
   logic                  req_tuser;   // func
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [79:0]           rsp_tdata;   // marker_index, out_x, out_y, out_z, 2 pad
   logic                  rsp_tuser;   // visible
   logic                  rsp_tlast;   // last_report
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int errors, reports_seen, reports_pending;
   int beats_sent = 0;
   int frames_sent = 0;
   bit no_gaps = 0;        // stretches where the sender never idles
   bit squeeze_done = 0;

   // simulated objects moving at constant velocity, source of well-formed points
   int obj_x[NOBJ], obj_y[NOBJ], obj_z[NOBJ];
   int obj_vx[NOBJ], obj_vy[NOBJ], obj_vz[NOBJ];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   marker_nearest_match_tracker u_top (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_we, .csr_addr, .csr_wdata
   );

   mnmt_tracker_check u_check (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_we, .csr_addr, .csr_wdata,
      .errors, .reports_seen, .reports_pending
   );

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
      return $urandom_range(5, 40);
   endfunction

   task automatic send(input logic f, input logic signed [23:0] x, y, z);
      int g;
      g = no_gaps ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {z, y, x};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      if (f != FUNC_POINT) frames_sent++;
   endtask

   task automatic point(input logic signed [23:0] x, y, z);
      send(FUNC_POINT, x, y, z);
   endtask

   task automatic frame_end();
      send(~FUNC_POINT, $urandom, $urandom, $urandom);
   endtask

   // drain all reports, then allow a point still in the scan to finish
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
      repeat (2 * MARKERS_DEFAULT + 10) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] a, input logic [CSR_DATA_W-1:0] d);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= d;
      @(posedge clock);
   endtask

   task automatic csr_done();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic place_objects();
      for (int i = 0; i < NOBJ; i++) begin
         obj_x[i] = $urandom_range(0, 400000) - 200000;
         obj_y[i] = $urandom_range(0, 400000) - 200000;
         obj_z[i] = $urandom_range(0, 400000) - 200000;
         obj_vx[i] = $urandom_range(0, 400) - 200;
         obj_vy[i] = $urandom_range(0, 400) - 200;
         obj_vz[i] = $urandom_range(0, 400) - 200;
      end
   endtask

   // frames of tracked points with jitter, plus noise and repeats
   task automatic random_frames(input int n);
      int stop, k, o, pick;
      stop = beats_sent + n;
      while (beats_sent < stop) begin
         no_gaps = ($urandom_range(0, 5) == 0);
         k = $urandom_range(0, 9);
         for (int i = 0; i < k; i++) begin
            pick = $urandom_range(0, 19);
            o = $urandom_range(0, NOBJ - 1);
            if (pick < 14)
               point(obj_x[o] + $urandom_range(0, 6) - 3, obj_y[o] + $urandom_range(0, 6) - 3,
                     obj_z[o] + $urandom_range(0, 6) - 3);
            else if (pick < 16)
               point(obj_x[o], obj_y[o], obj_z[o]);   // may repeat a point within a frame
            else if (pick < 18)
               point($urandom, $urandom, $urandom);   // full-range noise
            else
               point($urandom_range(0, 64) - 32, $urandom_range(0, 64) - 32,
                     $urandom_range(0, 64) - 32);     // clutter near origin
         end
         frame_end();
         for (int i = 0; i < NOBJ; i++) begin
            obj_x[i] += obj_vx[i];
            obj_y[i] += obj_vy[i];
            obj_z[i] += obj_vz[i];
         end
      end
   endtask

   // receiver: random ready pattern, one long hold-off while the sender keeps going
   initial begin
      int n;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (!squeeze_done && beats_sent >= 60) begin
            squeeze_done = 1;
            rsp_tready <= 1'b0;
            for (int c = 0; c < 400; c++) @(posedge clock);
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
            rsp_tready <= 1'b1;
            repeat (n) @(posedge clock);
            n = gap_len();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   initial begin
      #3000000;
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= FUNC_POINT;
      csr_we <= 1'b0;
      csr_addr <= '0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: extreme coordinates, exact rematch, repeat in one frame
      point(24'sh7FFFFF, 24'sh800000, 24'sd0);
      point(24'sh800000, 24'sh7FFFFF, -24'sd1);
      point(24'sd0, 24'sd0, 24'sd0);
      point(24'sd0, 24'sd0, 24'sd0);
      frame_end();
      point(24'sh7FFFFF, 24'sh800000, 24'sd0);
      point(24'sd10, 24'sd10, 24'sd10);
      point(24'sd12, 24'sd9, 24'sd10);
      frame_end();
      frame_end();
      place_objects();
      random_frames(110);
      settle();

      // wide open: every point matches, long memory, extrapolation saturates
      csr_write(CSR_MATCH_TOL, 48'hFFFF_FFFF_FFFF);
      csr_write(CSR_PRED_LIMIT, 48'd255);
      csr_write(CSR_TIMEOUT, 48'd255);
      csr_write(CSR_DEFAULT_X, 48'h7FFFFF);
      csr_write(CSR_DEFAULT_Y, 48'h800000);
      csr_write(CSR_DEFAULT_Z, 48'hFFFF_FF00_0000); // stray upper bits
      csr_write(3'd6, 48'h123456);                 // beyond the register list
      csr_done();
      point(24'sd8388000, -24'sd8388000, 24'sd8387900);
      frame_end();
      point(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
      frame_end();
      frame_end();
      frame_end();
      place_objects();
      random_frames(80);
      settle();

      // closed: nothing matches, slots expire at once
      csr_write(CSR_MATCH_TOL, 48'd0);
      csr_write(CSR_PRED_LIMIT, 48'd0);
      csr_write(CSR_TIMEOUT, 48'd0);
      csr_write(CSR_DEFAULT_X, 48'h800000);
      csr_write(CSR_DEFAULT_Y, 48'h7FFFFF);
      csr_write(CSR_DEFAULT_Z, 48'h000001);
      csr_done();
      place_objects();
      random_frames(70);
      settle();

      // middle ground
      csr_write(CSR_MATCH_TOL, 48'd4096);
      csr_write(CSR_PRED_LIMIT, 48'd2);
      csr_write(CSR_TIMEOUT, 48'd4);
      csr_write(CSR_DEFAULT_X, {24'd0, 24'($urandom)});
      csr_write(CSR_DEFAULT_Y, {24'd0, 24'($urandom)});
      csr_write(CSR_DEFAULT_Z, {24'd0, 24'($urandom)});
      csr_write(3'd7, '1);
      csr_done();
      place_objects();
      random_frames(110);
      settle();

      $display("tb: %0d beats sent over %0d frames, four register settings",
               beats_sent, frames_sent);
      $display("tb: %0d marker reports compared", reports_seen);
      if (errors == 0 && reports_pending == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
